FILE: src/jbcp_pkg.sv
// jbcp_pkg: shared types, codes and helper functions for the joybus command ram processor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package jbcp_pkg;

	// sizes
	localparam int DEF_NUM_CHANNELS = 6;
	localparam int DEF_PACK_BYTES   = 32768;
	localparam int RAM_BYTES        = 64;
	localparam int KIND_CHANNELS    = 6;

	localparam logic [5:0] CTL_ADDR = 6'd63;

	// length byte codes
	localparam logic [7:0] LEN_NEXT     = 8'h00;
	localparam logic [7:0] LEN_NEXT_ALT = 8'hFD;
	localparam logic [7:0] LEN_END      = 8'hFE;
	localparam logic [7:0] LEN_PAD_A    = 8'h56;
	localparam logic [7:0] LEN_PAD_B    = 8'hB4;
	localparam logic [7:0] LEN_PAD_C    = 8'hB8;
	localparam logic [7:0] LEN_PAD_D    = 8'hFF;

	// command indexes
	localparam logic [7:0] CMD_ID     = 8'h00;
	localparam logic [7:0] CMD_ID_ALT = 8'hFF;
	localparam logic [7:0] CMD_BTN    = 8'h01;
	localparam logic [7:0] CMD_PREAD  = 8'h02;
	localparam logic [7:0] CMD_PWRITE = 8'h03;

	localparam logic [7:0] CRC_POLY    = 8'h85;
	localparam logic [7:0] RLEN_MASK   = 8'h3F;
	localparam logic [7:0] NO_DEV_FLAG = 8'h80;
	localparam logic [7:0] RUMBLE_FILL = 8'h80;
	localparam logic [7:0] CTL_ERROR   = 8'h80;
	localparam logic [7:0] ID_BYTE0    = 8'h05;
	localparam logic [7:0] ID_ACC      = 8'h02;
	localparam logic [7:0] ID_NO_ACC   = 8'h01;

	// device and accessory kinds
	localparam logic [1:0] DEV_ABSENT = 2'd0;
	localparam logic [1:0] DEV_EMPTY  = 2'd1;
	localparam logic [1:0] DEV_PAD    = 2'd2;
	localparam logic [1:0] DEV_UNSUP  = 2'd3;
	localparam logic [1:0] ACC_MEM    = 2'd1;
	localparam logic [1:0] ACC_RUMBLE = 2'd2;

	// register indexes
	localparam logic REG_DEVICE_KINDS    = 1'b0;
	localparam logic REG_ACCESSORY_KINDS = 1'b1;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_LATCH = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_CMD = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_UNSUP   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [5:0]  address;
		logic [7:0]  data;
		logic [2:0]  channel;
		logic [31:0] pad_state;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] status;
	} rsp_t;

	// one byte through the crc, msb first
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] c;
		c = crc;
		for (int b = 7; b >= 0; b--) begin
			c = {c[6:0], din[b]} ^ (c[7] ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	// control byte after a control write
	function automatic logic [7:0] ctl_next(input logic [7:0] ctl);
		logic [7:0] v;
		v = ctl;
		if (ctl[0]) v = 8'h00;
		if (ctl[1]) v[1] = 1'b0;
		if (ctl[3]) v[3] = 1'b0;
		if (ctl[5:4] != 2'b00) v = CTL_ERROR;
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: src/joybus_command_ram_processor.sv
// joybus_command_ram_processor: command ram, pad latches, command walk and pack memory
// depends on jbcp_pkg
// a control write with bit 0 set runs the walk, which ends with a control update and the result;
// a copied pack read copies the bytes first and then runs the crc over them.
// one item at a time; a finished result waits in the output register while the next is taken.
// reset clears control state, ram valid bits and pad latches, then a clearing pass zeroes
// all PACK_BYTES bytes of the pack memory; no item is taken during it.
`timescale 1ns / 1ps
`default_nettype none
module joybus_command_ram_processor #(
	parameter int NUM_CHANNELS = jbcp_pkg::DEF_NUM_CHANNELS,
	parameter int PACK_BYTES   = jbcp_pkg::DEF_PACK_BYTES
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire jbcp_pkg::req_t req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output jbcp_pkg::rsp_t      rsp,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire                 cfg_index,
	input  wire [11:0]          cfg_data
);
	import jbcp_pkg::*;

	localparam int PA_W = $clog2(PACK_BYTES);

	typedef enum logic [19:0] {
		S_CLEAR    = 20'h00001,
		S_IDLE     = 20'h00002,
		S_RD       = 20'h00004,
		S_FIN      = 20'h00008,
		S_CTL      = 20'h00010,
		S_W_CHK    = 20'h00020,
		S_W_LEN    = 20'h00040,
		S_W_B1     = 20'h00080,
		S_W_IDX    = 20'h00100,
		S_W_O3     = 20'h00200,
		S_W_O4     = 20'h00400,
		S_ID_WR    = 20'h00800,
		S_BTN_WR   = 20'h01000,
		S_BTN_RA   = 20'h02000,
		S_BTN_RD   = 20'h04000,
		S_PR_ISSUE = 20'h08000,
		S_PR_WR    = 20'h10000,
		S_CRC_RD   = 20'h20000,
		S_CRC_D    = 20'h40000,
		S_CRC_WR   = 20'h80000
	} state_t;

	state_t state_q;

	// configuration
	logic [11:0] dev_kinds_q, acc_kinds_q;

	// command ram with per-byte valid bits
	logic [7:0]  ram_mem [RAM_BYTES];
	logic [RAM_BYTES-1:0] ram_vld_q;
	logic [7:0]  ram_dq;
	logic        ram_vq;
	logic        ram_we;
	logic [5:0]  ram_waddr, ram_raddr;
	logic [7:0]  ram_wdata, ram_rd;

	// pack memory
	logic [7:0]  pack_mem [PACK_BYTES];
	logic [7:0]  pack_dq;
	logic        pk_we;
	logic [PA_W-1:0] pk_waddr, pk_raddr, clr_q;
	logic [15:0] pk_idx;

	// pad latches
	logic [31:0] pad_q [NUM_CHANNELS];

	// walk state
	logic [8:0]  cursor_q;
	logic [5:0]  c_q, res_q, base_q;
	logic [7:0]  len_q, ctl_q, crc_q, off_hi_q;
	logic [15:0] off_q;
	logic [4:0]  i_q;
	logic [6:0]  ch_q;
	logic        is_wr_q, mem_ok_q, rumble_q;
	logic [1:0]  status_q;
	logic [7:0]  rdata_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        acc;
	logic        out_free;
	logic [1:0]  dk, ak;
	logic [31:0] pad_sel;
	logic [7:0]  id_byte, btn_byte, crc_fin;
	logic [6:0]  ch_inc;
	logic [15:0] off_w;
	logic        mem_ok_w;

	assign req_stall = (state_q != S_IDLE);
	assign acc       = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign ram_rd    = ram_vq ? ram_dq : 8'h00;
	assign ch_inc    = ch_q + 7'd1;
	assign crc_fin   = crc_byte(crc_q, 8'h00);
	assign pk_idx    = {off_q[15:5], i_q};
	assign off_w     = {off_hi_q, ram_rd & 8'hE0};
	assign mem_ok_w  = (dk != DEV_ABSENT) && (ak == ACC_MEM) &&
		({1'b0, off_w} <= 17'(PACK_BYTES - 32));

	// device and accessory kind of the current channel
	always_comb begin
		dk      = DEV_ABSENT;
		ak      = 2'd0;
		pad_sel = 32'h0;
		for (int k = 0; k < KIND_CHANNELS; k++) begin
			if (k < NUM_CHANNELS && ch_q == 7'(k)) begin
				dk = dev_kinds_q[2*k +: 2];
				ak = acc_kinds_q[2*k +: 2];
			end
		end
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			if (ch_q == 7'(k)) pad_sel = pad_q[k];
		end
	end

	// result bytes of id query and button read
	always_comb begin
		id_byte  = 8'h00;
		btn_byte = 8'h00;
		if (dk == DEV_PAD) begin
			case (i_q[1:0])
				2'd0: id_byte = ID_BYTE0;
				2'd2: id_byte = (ak == ACC_MEM || ak == ACC_RUMBLE) ? ID_ACC : ID_NO_ACC;
				default: id_byte = 8'h00;
			endcase
			case (i_q[1:0])
				2'd0: btn_byte = pad_sel[31:24];
				2'd1: btn_byte = pad_sel[23:16];
				2'd2: btn_byte = pad_sel[15:8];
				default: btn_byte = pad_sel[7:0];
			endcase
		end
	end

	// command ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = 6'd0;
		ram_wdata = 8'h00;
		ram_raddr = 6'd0;
		case (state_q)
			S_IDLE: begin
				if (acc && req.func == FUNC_WRITE) begin
					ram_we    = 1'b1;
					ram_waddr = req.address;
					ram_wdata = (req.address == CTL_ADDR && !req.data[0]) ?
						ctl_next(req.data) : req.data;
				end
				ram_raddr = req.address;
			end
			S_W_CHK: ram_raddr = cursor_q[5:0];
			S_W_LEN: ram_raddr = c_q + 6'd1;
			S_W_B1:  ram_raddr = c_q + 6'd2;
			S_W_IDX: ram_raddr = c_q + 6'd3;
			S_W_O3:  ram_raddr = c_q + 6'd4;
			S_ID_WR: begin
				ram_we    = 1'b1;
				ram_waddr = res_q + 6'(i_q);
				ram_wdata = id_byte;
			end
			S_BTN_WR: begin
				ram_we    = 1'b1;
				ram_waddr = res_q + 6'(i_q);
				ram_wdata = btn_byte;
			end
			S_BTN_RA: ram_raddr = c_q + 6'd1;
			S_BTN_RD: begin
				ram_we    = 1'b1;
				ram_waddr = c_q + 6'd1;
				ram_wdata = ram_rd | NO_DEV_FLAG;
			end
			S_PR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = res_q + 6'(i_q);
				ram_wdata = rumble_q ? RUMBLE_FILL : pack_dq;
			end
			S_CRC_RD: ram_raddr = base_q + 6'(i_q);
			S_CRC_WR: begin
				ram_we    = 1'b1;
				ram_waddr = is_wr_q ? res_q : res_q + 6'd32;
				ram_wdata = crc_fin;
			end
			S_CTL: begin
				ram_we    = 1'b1;
				ram_waddr = CTL_ADDR;
				ram_wdata = ctl_next(ctl_q);
			end
			default: ram_raddr = 6'd0;
		endcase
	end

	// command ram storage
	always_ff @(posedge clk) begin
		if (ram_we) ram_mem[ram_waddr] <= ram_wdata;
		ram_dq <= ram_mem[ram_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q <= '0;
			ram_vq    <= 1'b0;
		end else begin
			if (ram_we) ram_vld_q[ram_waddr] <= 1'b1;
			ram_vq <= ram_vld_q[ram_raddr];
		end
	end

	// pack memory port control and storage
	assign pk_we    = (state_q == S_CLEAR) || (state_q == S_CRC_D && is_wr_q && mem_ok_q);
	assign pk_waddr = (state_q == S_CLEAR) ? clr_q : pk_idx[PA_W-1:0];
	assign pk_raddr = pk_idx[PA_W-1:0];

	always_ff @(posedge clk) begin
		if (pk_we) pack_mem[pk_waddr] <= (state_q == S_CLEAR) ? 8'h00 : ram_rd;
		pack_dq <= pack_mem[pk_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_kinds_q <= '0;
			acc_kinds_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DEVICE_KINDS) dev_kinds_q <= cfg_data;
			if (cfg_index == REG_ACCESSORY_KINDS) acc_kinds_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int k = 0; k < NUM_CHANNELS; k++) pad_q[k] <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) rsp_valid_q <= 1'b0;
			case (state_q)
				// zero the pack memory
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PA_W'(PACK_BYTES - 1)) state_q <= S_IDLE;
				end
				// take a new item
				S_IDLE: begin
					if (acc) begin
						rdata_q  <= 8'h00;
						status_q <= ST_OK;
						ctl_q    <= req.data;
						cursor_q <= '0;
						ch_q     <= '0;
						case (req.func)
							FUNC_WRITE: begin
								state_q <= (req.address == CTL_ADDR && req.data[0]) ?
									S_W_CHK : S_FIN;
							end
							FUNC_READ: state_q <= S_RD;
							FUNC_LATCH: begin
								for (int k = 0; k < NUM_CHANNELS; k++) begin
									if (req.channel == 3'(k)) pad_q[k] <= req.pad_state;
								end
								state_q <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_RD: begin
					rdata_q <= ram_rd;
					state_q <= S_FIN;
				end
				// hand the result to the output register
				S_FIN: begin
					if (out_free) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.read_data   <= rdata_q;
						rsp_q.status      <= status_q;
						state_q           <= S_IDLE;
					end
				end
				S_CTL: state_q <= S_FIN;
				// walk loop head
				S_W_CHK: begin
					c_q <= cursor_q[5:0];
					state_q <= (cursor_q < 9'd63) ? S_W_LEN : S_CTL;
				end
				// length byte
				S_W_LEN: begin
					len_q    <= ram_rd;
					cursor_q <= cursor_q + 9'd1;
					case (ram_rd) inside
						LEN_NEXT, LEN_NEXT_ALT: begin
							ch_q    <= ch_inc;
							state_q <= (ch_inc >= 7'(NUM_CHANNELS)) ? S_CTL : S_W_CHK;
						end
						LEN_END: state_q <= S_CTL;
						LEN_PAD_A, LEN_PAD_B, LEN_PAD_C, LEN_PAD_D: state_q <= S_W_CHK;
						default: state_q <= S_W_B1;
					endcase
				end
				// result length byte
				S_W_B1: begin
					if (ram_rd == LEN_END) begin
						state_q <= S_CTL;
					end else begin
						cursor_q <= 9'(c_q) + 9'd2 + 9'(len_q) + 9'(ram_rd & RLEN_MASK);
						res_q    <= c_q + 6'd2 + len_q[5:0];
						state_q  <= S_W_IDX;
					end
				end
				// command index
				S_W_IDX: begin
					i_q     <= '0;
					is_wr_q <= (ram_rd == CMD_PWRITE);
					case (ram_rd) inside
						CMD_ID, CMD_ID_ALT: begin
							if (dk == DEV_ABSENT) begin
								status_q <= ST_ABSENT;
								state_q  <= S_CTL;
							end else if (dk == DEV_UNSUP) begin
								status_q <= ST_UNSUP;
								state_q  <= S_CTL;
							end else begin
								state_q <= S_ID_WR;
							end
						end
						CMD_BTN: state_q <= S_BTN_WR;
						CMD_PREAD, CMD_PWRITE: state_q <= S_W_O3;
						default: begin
							status_q <= ST_BAD_CMD;
							state_q  <= S_CTL;
						end
					endcase
				end
				S_W_O3: begin
					off_hi_q <= ram_rd;
					state_q  <= S_W_O4;
				end
				// pack offset complete, pick the copy path
				S_W_O4: begin
					off_q    <= off_w;
					mem_ok_q <= mem_ok_w;
					rumble_q <= (dk != DEV_ABSENT) && (ak == ACC_RUMBLE);
					crc_q    <= 8'h00;
					base_q   <= is_wr_q ? c_q + 6'd5 : res_q;
					if (!is_wr_q && (mem_ok_w || ((dk != DEV_ABSENT) && (ak == ACC_RUMBLE))))
						state_q <= S_PR_ISSUE;
					else
						state_q <= S_CRC_RD;
				end
				S_ID_WR: begin
					i_q <= i_q + 5'd1;
					if (i_q == 5'd2) begin
						ch_q    <= ch_inc;
						state_q <= S_W_CHK;
					end
				end
				S_BTN_WR: begin
					i_q <= i_q + 5'd1;
					if (i_q == 5'd3) begin
						if (dk == DEV_PAD) begin
							ch_q    <= ch_inc;
							state_q <= S_W_CHK;
						end else begin
							state_q <= S_BTN_RA;
						end
					end
				end
				S_BTN_RA: state_q <= S_BTN_RD;
				S_BTN_RD: begin
					ch_q    <= ch_inc;
					state_q <= S_W_CHK;
				end
				// pack read copy, an issue and a write for each byte
				S_PR_ISSUE: state_q <= S_PR_WR;
				S_PR_WR: begin
					i_q <= i_q + 5'd1;
					state_q <= (i_q == 5'd31) ? S_CRC_RD : S_PR_ISSUE;
				end
				// crc over 32 ram bytes, pack write rides along
				S_CRC_RD: state_q <= S_CRC_D;
				S_CRC_D: begin
					crc_q <= crc_byte(crc_q, ram_rd);
					i_q   <= i_q + 5'd1;
					state_q <= (i_q == 5'd31) ? S_CRC_WR : S_CRC_RD;
				end
				S_CRC_WR: state_q <= S_W_CHK;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
